// ===== hw/rtl/afs_pkg.sv =====
// afs_pkg: shared types, request codes and frame-count compare points
// for the audio frame sequencer
// no dependencies
package afs_pkg;

	localparam int CountW = 16;

	typedef logic [1:0] req_code_t;
	localparam req_code_t REQ_TICK  = 2'd0;
	localparam req_code_t REQ_WRITE = 2'd1;
	localparam req_code_t REQ_READ  = 2'd2;

	// four-step sequence
	localparam logic [CountW-1:0] Q4_A       = 16'd7456;
	localparam logic [CountW-1:0] Q4_B       = 16'd14912;
	localparam logic [CountW-1:0] Q4_C       = 16'd22370;
	localparam logic [CountW-1:0] Q4_D       = 16'd29828;
	localparam logic [CountW-1:0] IRQ4_FIRST = 16'd29827;
	localparam logic [CountW-1:0] IRQ4_LAST  = 16'd29829;
	localparam logic [CountW-1:0] END4       = 16'd29830;
	// five-step sequence
	localparam logic [CountW-1:0] Q5_A       = 16'd7457;
	localparam logic [CountW-1:0] Q5_B       = 16'd14913;
	localparam logic [CountW-1:0] Q5_C       = 16'd22371;
	localparam logic [CountW-1:0] Q5_D       = 16'd37281;
	localparam logic [CountW-1:0] END5       = 16'd37282;

	localparam logic [7:0] BARE_FIVE_STEP = 8'h80;

	// mode write delays
	localparam logic [2:0] MODE_DELAY_ODD  = 3'd4;
	localparam logic [2:0] MODE_DELAY_EVEN = 3'd5;
	// status read clear delays
	localparam logic [1:0] CLR_DELAY_ODD   = 2'd1;
	localparam logic [1:0] CLR_DELAY_EVEN  = 2'd2;

	typedef struct packed {
		req_code_t  req_type;
		logic [7:0] write_data;
		logic       cycle_odd;
		logic [4:0] channels_active;
		logic       dmc_irq;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       quarter_frame;
		logic       half_frame;
		logic       frame_irq;
	} rsp_t;

endpackage

// ===== hw/rtl/afs_req_if.sv =====
// afs_req_if: request channel of the audio frame sequencer
// depends on afs_pkg
interface afs_req_if import afs_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/afs_rsp_if.sv =====
// afs_rsp_if: result channel of the audio frame sequencer
// depends on afs_pkg
interface afs_rsp_if import afs_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/afs_core.sv =====
// afs_core: sequencer state and the combinational next-state and result logic
// depends on afs_pkg
module afs_core import afs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  req_t item,
	output rsp_t result
);

	logic [CountW-1:0] frame_count_q, fc_d;
	logic              five_q, five_d;
	logic              inhibit_q, inhibit_d;
	logic              irq_q, irq_d;
	logic              clr_pend_q, clr_pend_d;
	logic [1:0]        clr_delay_q, clr_delay_d;
	logic [2:0]        rst_delay_q, rst_delay_d;
	logic [7:0]        mode_byte_q, mode_byte_d;
	logic              qf, hf;
	logic [7:0]        rd;

	always_comb begin
		fc_d        = frame_count_q;
		five_d      = five_q;
		inhibit_d   = inhibit_q;
		irq_d       = irq_q;
		clr_pend_d  = clr_pend_q;
		clr_delay_d = clr_delay_q;
		rst_delay_d = rst_delay_q;
		mode_byte_d = mode_byte_q;
		qf          = 1'b0;
		hf          = 1'b0;
		rd          = '0;
		case (item.req_type)
			REQ_TICK: begin
				fc_d = frame_count_q + CountW'(1);
				if (clr_pend_q && clr_delay_q != '0) begin
					clr_delay_d = clr_delay_q - 2'd1;
					if (clr_delay_d == '0) begin
						irq_d      = 1'b0;
						clr_pend_d = 1'b0;
					end
				end
				if (rst_delay_q != '0) begin
					rst_delay_d = rst_delay_q - 3'd1;
					if (rst_delay_d == '0) begin
						five_d    = mode_byte_q[7];
						inhibit_d = mode_byte_q[6];
						if (mode_byte_q[6])
							irq_d = 1'b0;
						fc_d = '0;
						// five-step mode strobes at once on reset
						qf = mode_byte_q[7];
						hf = mode_byte_q[7];
					end
				end
				if (!five_d) begin
					if (fc_d == Q4_A || fc_d == Q4_B || fc_d == Q4_C || fc_d == Q4_D)
						qf = 1'b1;
					if (fc_d == Q4_B || fc_d == Q4_D)
						hf = 1'b1;
					// last irq tick clears instead when inhibited
					if (fc_d >= IRQ4_FIRST && fc_d <= IRQ4_LAST)
						irq_d = !(fc_d == IRQ4_LAST && inhibit_d);
					if (fc_d == END4)
						fc_d = '0;
				end else begin
					if (fc_d == Q5_A || fc_d == Q5_B || fc_d == Q5_C || fc_d == Q5_D)
						qf = 1'b1;
					if (fc_d == Q5_B || fc_d == Q5_D)
						hf = 1'b1;
					if (fc_d == END5)
						fc_d = '0;
				end
			end
			REQ_WRITE: begin
				mode_byte_d = item.write_data;
				rst_delay_d = item.cycle_odd ? MODE_DELAY_ODD : MODE_DELAY_EVEN;
				if (item.write_data == BARE_FIVE_STEP)
					rst_delay_d = rst_delay_d - 3'd1;
			end
			REQ_READ: begin
				rd          = {item.dmc_irq, irq_q, 1'b0, item.channels_active};
				clr_delay_d = item.cycle_odd ? CLR_DELAY_ODD : CLR_DELAY_EVEN;
				clr_pend_d  = 1'b1;
			end
			default: ;
		endcase
	end

	assign result = '{read_data: rd, quarter_frame: qf, half_frame: hf, frame_irq: irq_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			five_q        <= 1'b0;
			inhibit_q     <= 1'b0;
			irq_q         <= 1'b0;
			clr_pend_q    <= 1'b0;
			clr_delay_q   <= '0;
			rst_delay_q   <= '0;
			mode_byte_q   <= '0;
		end else if (en) begin
			frame_count_q <= fc_d;
			five_q        <= five_d;
			inhibit_q     <= inhibit_d;
			irq_q         <= irq_d;
			clr_pend_q    <= clr_pend_d;
			clr_delay_q   <= clr_delay_d;
			rst_delay_q   <= rst_delay_d;
			mode_byte_q   <= mode_byte_d;
		end
	end

endmodule

// ===== hw/rtl/audio_frame_sequencer.sv =====
// audio_frame_sequencer: top level; input register, sequencer core, result register
// depends on afs_pkg, afs_req_if, afs_rsp_if, afs_core
//
//  channel  dir   payload                                            use
//  req      in    req_type, write_data, cycle_odd, channels_active,   tick, mode write,
//                 dmc_irq                                            status read
//  rsp      out   read_data, quarter_frame, half_frame, frame_irq    one per request
//
// one request per cycle while rsp is not stalled; rsp.valid rises after the request
// has passed the input register, then core logic into the result register
// reset clears the sequencer state and both valid bits, no clearing pass
// a stalled rsp holds its result; req is still taken while the input stage is empty
module audio_frame_sequencer import afs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	afs_req_if.sink   req,
	afs_rsp_if.source rsp
);

	logic valid_s1;
	req_t item_s1;
	logic advance;
	rsp_t result;
	logic out_valid_q;
	rsp_t out_q;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (req.ready)
			valid_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= req.data;
	end

	afs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule

// ===== hw/rtl/afs_chk.sv =====
// afs_chk: port-level checks on the audio frame sequencer, bound to the top level
// depends on afs_pkg, audio_frame_sequencer
module afs_chk import afs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("afs: stalled result changed");

	// every half-frame point is also a quarter-frame point
	a_half_implies_quarter: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.half_frame |-> rsp_data.quarter_frame)
		else $error("afs: half frame without quarter frame");

	// status bit 5 is always zero
	a_bit5_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !rsp_data.read_data[5])
		else $error("afs: status bit 5 set");

	// a read that reports the irq set leaves frame_irq set and does not strobe
	a_read_irq: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.read_data[6] |->
			rsp_data.frame_irq && !rsp_data.quarter_frame && !rsp_data.half_frame)
		else $error("afs: status irq bit disagrees with frame irq");

endmodule

bind audio_frame_sequencer afs_chk u_afs_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== tb/tb_audio_frame_sequencer.sv =====
`timescale 1ns / 100ps
// tb_audio_frame_sequencer: self-checking bench for the frame sequencer, opening table then
// random episodes under idling, steady stretches and long result hold-offs
// depends on afs_pkg, afs_req_if, afs_rsp_if and audio_frame_sequencer
module tb_audio_frame_sequencer;
	import afs_pkg::*;

	localparam req_code_t REQ_UNUSED = 2'd3;
	localparam int IDLE_PCT      = 27;
	localparam int EPISODES      = 28;
	localparam int EPISODE_ITEMS = 25;
	localparam int HOLD_CYCLES   = 80;
	localparam int MAX_SHOWN     = 40;
	localparam int DRAIN_LIMIT   = 20000;

	typedef struct packed {
		req_t item;
		logic typed;
		rsp_t want;
	} dir_row_t;

	// typed rows: status after reset, ignored fields, unused code, bare five-step strobes
	localparam dir_row_t OPENING_ROWS [25] = '{
		'{'{REQ_READ,   8'h00, 1'b0, 5'h1f, 1'b1}, 1'b1, '{8'h9f, 1'b0, 1'b0, 1'b0}},
		'{'{REQ_TICK,   8'hff, 1'b1, 5'h1f, 1'b1}, 1'b1, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b1, '0},
		'{'{REQ_UNUSED, 8'hff, 1'b1, 5'h1f, 1'b1}, 1'b1, '0},
		'{'{REQ_WRITE,  BARE_FIVE_STEP, 1'b1, 5'h00, 1'b0}, 1'b1, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b1, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b1, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b0}},
		'{'{REQ_WRITE,  BARE_FIVE_STEP, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_WRITE,  8'hc0, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		// second write restarts the delay and replaces the byte
		'{'{REQ_WRITE,  8'h40, 1'b1, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_READ,   8'h00, 1'b1, 5'h0a, 1'b0}, 1'b0, '0},
		'{'{REQ_TICK,   8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_WRITE,  8'h7f, 1'b1, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_READ,   8'h00, 1'b0, 5'h15, 1'b1}, 1'b0, '0},
		'{'{REQ_UNUSED, 8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0},
		'{'{REQ_WRITE,  8'h00, 1'b0, 5'h00, 1'b0}, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	afs_req_if req_bus ();
	afs_rsp_if rsp_bus ();

	audio_frame_sequencer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// sequencer state as the block should hold it after every accepted request
	logic [15:0] seq_count   = '0;
	logic        seq_five    = 1'b0;
	logic        seq_inhibit = 1'b0;
	logic        seq_irq     = 1'b0;
	logic        clr_armed   = 1'b0;
	logic [1:0]  clr_wait    = '0;
	logic [2:0]  mode_wait   = '0;
	logic [7:0]  mode_byte   = '0;

	rsp_t frame_rsp_q [$];

	int  mismatches      = 0;
	int  results_checked = 0;
	int  requests_sent   = 0;
	int  status_reads    = 0;
	int  mode_writes     = 0;
	int  unused_codes    = 0;
	int  quarter_strobes = 0;
	int  half_strobes    = 0;
	int  irq_raises      = 0;
	bit  steady          = 1'b0;
	bit  hold_off_due    = 1'b0;

	function automatic rsp_t advance_sequencer(req_t r);
		rsp_t o;
		o = '0;
		case (r.req_type)
			REQ_TICK: begin
				seq_count = seq_count + 16'd1;
				if (clr_armed && clr_wait != 2'd0) begin
					clr_wait = clr_wait - 2'd1;
					if (clr_wait == 2'd0) begin
						seq_irq   = 1'b0;
						clr_armed = 1'b0;
					end
				end
				if (mode_wait != 3'd0) begin
					mode_wait = mode_wait - 3'd1;
					if (mode_wait == 3'd0) begin
						seq_five    = mode_byte[7];
						seq_inhibit = mode_byte[6];
						if (seq_inhibit)
							seq_irq = 1'b0;
						seq_count = '0;
						if (seq_five) begin
							o.quarter_frame = 1'b1;
							o.half_frame    = 1'b1;
						end
					end
				end
				if (!seq_five) begin
					if (seq_count == Q4_A || seq_count == Q4_B || seq_count == Q4_C ||
					    seq_count == Q4_D)
						o.quarter_frame = 1'b1;
					if (seq_count == Q4_B || seq_count == Q4_D)
						o.half_frame = 1'b1;
					// last tick of the irq window drops the flag when inhibited
					if (seq_count >= IRQ4_FIRST && seq_count <= IRQ4_LAST)
						seq_irq = !(seq_count == IRQ4_LAST && seq_inhibit);
					if (seq_count == END4)
						seq_count = '0;
				end else begin
					if (seq_count == Q5_A || seq_count == Q5_B || seq_count == Q5_C ||
					    seq_count == Q5_D)
						o.quarter_frame = 1'b1;
					if (seq_count == Q5_B || seq_count == Q5_D)
						o.half_frame = 1'b1;
					if (seq_count == END5)
						seq_count = '0;
				end
			end
			REQ_WRITE: begin
				mode_byte = r.write_data;
				mode_wait = r.cycle_odd ? MODE_DELAY_ODD : MODE_DELAY_EVEN;
				if (r.write_data == BARE_FIVE_STEP)
					mode_wait = mode_wait - 3'd1;
			end
			REQ_READ: begin
				o.read_data = {r.dmc_irq, seq_irq, 1'b0, r.channels_active};
				clr_wait    = r.cycle_odd ? CLR_DELAY_ODD : CLR_DELAY_EVEN;
				clr_armed   = 1'b1;
			end
			default: begin
			end
		endcase
		o.frame_irq = seq_irq;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("mismatch at result %0d, %s: got %0h, expected %0h",
				results_checked, what, got, want);
	endtask

	// drives one request, waits for it to be taken and queues what it should produce
	task automatic send_request(req_t item, bit typed = 1'b0, rsp_t want = '0);
		rsp_t predicted;
		bit   irq_was;
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_bus.valid <= 1'b0;
			@(negedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.data  <= item;
		do @(posedge clk); while (!req_bus.ready);
		irq_was   = seq_irq;
		predicted = advance_sequencer(item);
		frame_rsp_q = {frame_rsp_q, (typed ? want : predicted)};
		requests_sent++;
		case (item.req_type)
			REQ_READ:  status_reads++;
			REQ_WRITE: mode_writes++;
			REQ_TICK:  ;
			default:   unused_codes++;
		endcase
		if (predicted.quarter_frame)
			quarter_strobes++;
		if (predicted.half_frame)
			half_strobes++;
		if (predicted.frame_irq && !irq_was)
			irq_raises++;
		@(negedge clk);
	endtask

	function automatic req_t random_request();
		req_t r;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 66)
			r.req_type = REQ_TICK;
		else if (pick < 88)
			r.req_type = REQ_READ;
		else if (pick < 93)
			r.req_type = REQ_WRITE;
		else
			r.req_type = REQ_UNUSED;
		r.write_data      = ($urandom_range(3) == 0) ? BARE_FIVE_STEP : 8'($urandom);
		r.cycle_odd       = 1'($urandom);
		r.channels_active = 5'($urandom);
		r.dmc_irq         = 1'($urandom);
		return r;
	endfunction

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (frame_rsp_q.size() == 0) begin
				report_mismatch("result with nothing expected", 16'(rsp_bus.data), '0);
			end else begin
				want = frame_rsp_q.pop_front();
				if (rsp_bus.data.read_data !== want.read_data)
					report_mismatch("read_data", 16'(rsp_bus.data.read_data),
						16'(want.read_data));
				if (rsp_bus.data.quarter_frame !== want.quarter_frame)
					report_mismatch("quarter_frame", 16'(rsp_bus.data.quarter_frame),
						16'(want.quarter_frame));
				if (rsp_bus.data.half_frame !== want.half_frame)
					report_mismatch("half_frame", 16'(rsp_bus.data.half_frame),
						16'(want.half_frame));
				if (rsp_bus.data.frame_irq !== want.frame_irq)
					report_mismatch("frame_irq", 16'(rsp_bus.data.frame_irq),
						16'(want.frame_irq));
			end
			results_checked++;
		end
	end

	// result side pacing; flags are picked up at the rising edge, acted on at the falling one
	initial begin : rsp_pacing
		bit start_hold;
		bit calm;
		rsp_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			start_hold = hold_off_due;
			calm       = steady;
			@(negedge clk);
			if (start_hold) begin
				hold_off_due = 1'b0;
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : stimulus
		int guard;
		req_bus.valid = 1'b0;
		req_bus.data  = '0;
		arst_n        = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (OPENING_ROWS[i])
			send_request(OPENING_ROWS[i].item, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);

		for (int ep = 0; ep < EPISODES; ep++) begin
			steady = (ep >= 12 && ep < 16);
			if (ep == 5 || ep == 21)
				hold_off_due = 1'b1;
			repeat (EPISODE_ITEMS)
				send_request(random_request());
		end
		steady = 1'b0;
		req_bus.valid <= 1'b0;

		guard = 0;
		while (frame_rsp_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (frame_rsp_q.size() != 0)
			report_mismatch("results never returned", 16'(frame_rsp_q.size()), '0);

		$display("covered %0d requests: %0d status reads, %0d mode writes, %0d unused codes",
			requests_sent, status_reads, mode_writes, unused_codes);
		$display("saw %0d quarter-frame and %0d half-frame strobes, frame irq raised %0d times",
			quarter_strobes, half_strobes, irq_raises);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
